// ===== rtl/mrsp_pkg.sv =====
// Shared types and constants for the special-prime Montgomery reduction core.
package mrsp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int INDEX_BITS = 4;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   // Kind of a request transaction, carried on tuser.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_PRODUCT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

endpackage

// ===== rtl/mrsp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mrsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 14
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/montgomery_reduce_special_prime_core.sv =====
// Top level: column-order Montgomery reduction for a prime with zero low words in p+1.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_tvalid/req_tready  | tuser = kind, tdata = index, word
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata = word, index; tlast = last
//
// A load is written to the table RAM at accept when its index is below WORDS. A product word
// with terms goes through the accept step, one multiply-accumulate per term through the two
// table RAMs and the 32x32 multiplier, the pipeline drain and the retire step of the column.
// A column without terms goes from accept straight to the retire step.
// Reset is synchronous; the table RAMs are not cleared and must be loaded before use.
// A stalled result holds only the retire step of the next result column; until then new requests are taken.
module montgomery_reduce_special_prime_core #(
   parameter int WORDS      = 14,
   parameter int ZERO_WORDS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [3:0] table_index, [35:4] data_word, [39:36] zero
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_word, [35:32] result_index, [39:36] zero
   output logic        rsp_tlast
);

   localparam int WB  = mrsp_pkg::WORD_BITS;
   localparam int AW  = $clog2(WORDS);
   localparam int CW  = $clog2(2 * WORDS);
   localparam int HW  = $clog2(WORDS + 2);
   localparam int ZWM = (ZERO_WORDS > 0) ? ZERO_WORDS : 1;

   mrsp_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   column_ff, column_in;
   logic [AW-1:0]   j_ff, j_in;
   logic [AW-1:0]   jhi_ff, jhi_in;
   logic            v1_ff, v2_ff;
   logic [2*WB-1:0] prod_ff;
   logic [WB-1:0]   acc_low_ff, acc_low_in;
   logic [WB-1:0]   acc_mid_ff, acc_mid_in;
   logic [HW-1:0]   acc_high_ff, acc_high_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]   rsp_word_ff;
   logic [mrsp_pkg::INDEX_BITS-1:0] rsp_index_ff;
   logic            rsp_last_ff;

   logic [mrsp_pkg::INDEX_BITS-1:0] req_index;
   logic [WB-1:0]   req_word;
   logic            req_fire, load_fire, prod_fire;
   logic            index_ok;
   logic [CW-1:0]   jlo, jhi_a, jhi, k_addr;
   logic            has_terms;
   logic            is_quot_col, is_last_col, fin_fire;
   logic [WB-1:0]   q_rd, m_rd;
   logic [2*WB-1:0] addend;
   logic [2*WB:0]   sum;

   assign req_index = req_tdata[3:0];
   assign req_word  = req_tdata[35:4];

   assign req_tready = (state_ff == mrsp_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == mrsp_pkg::REQ_LOAD);
   assign prod_fire  = req_fire && (req_tuser == mrsp_pkg::REQ_PRODUCT);
   assign index_ok   = (32'(req_index) < 32'(WORDS));

   // Term range for the current column: j from jlo to jhi, with c-j inside the
   // nonzero part of the table and j below both c and WORDS.
   always_comb begin
      jlo   = (32'(column_ff) >= 32'(WORDS)) ? (column_ff - CW'(WORDS - 1)) : '0;
      jhi_a = column_ff - CW'(ZWM);
      jhi   = (32'(jhi_a) > 32'(WORDS - 1)) ? CW'(WORDS - 1) : jhi_a;
      has_terms = (32'(column_ff) >= 32'(ZWM)) && (jlo <= jhi);
   end

   assign k_addr      = column_ff - CW'(j_ff);
   assign is_quot_col = (32'(column_ff) < 32'(WORDS));
   assign is_last_col = (32'(column_ff) == 32'(2 * WORDS - 1));
   assign fin_fire    = (state_ff == mrsp_pkg::ST_FIN)
                        && (is_quot_col || !rsp_valid_ff || rsp_tready);

   mrsp_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_table_ram (
      .clock   (clock),
      .wr_en   (load_fire && index_ok),
      .wr_addr (AW'(req_index)),
      .wr_data (req_word),
      .rd_addr (AW'(k_addr)),
      .rd_data (m_rd)
   );

   mrsp_ram #(.WIDTH(WB), .DEPTH(WORDS)) u_quot_ram (
      .clock   (clock),
      .wr_en   (fin_fire && is_quot_col),
      .wr_addr (AW'(column_ff)),
      .wr_data (acc_low_ff),
      .rd_addr (j_ff),
      .rd_data (q_rd)
   );

   always_comb begin
      state_in  = state_ff;
      column_in = column_ff;
      j_in      = j_ff;
      jhi_in    = jhi_ff;
      unique case (state_ff)
         mrsp_pkg::ST_IDLE: begin
            if (prod_fire) begin
               j_in   = AW'(jlo);
               jhi_in = AW'(jhi);
               state_in = has_terms ? mrsp_pkg::ST_MAC : mrsp_pkg::ST_FIN;
            end
         end
         mrsp_pkg::ST_MAC: begin
            if (j_ff == jhi_ff) begin
               state_in = mrsp_pkg::ST_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         mrsp_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = mrsp_pkg::ST_FIN;
            end
         end
         mrsp_pkg::ST_FIN: begin
            if (fin_fire) begin
               state_in  = mrsp_pkg::ST_IDLE;
               column_in = is_last_col ? '0 : column_ff + CW'(1);
            end
         end
         default: begin
            state_in = mrsp_pkg::ST_IDLE;
         end
      endcase
   end

   // Accumulator: the product word enters at accept, products as they leave the
   // multiplier, and the retire step shifts the three words down by one, or clears them at the last column.
   always_comb begin
      addend = prod_fire ? {{WB{1'b0}}, req_word} : prod_ff;
      sum    = {1'b0, acc_mid_ff, acc_low_ff} + {1'b0, addend};
      acc_low_in  = acc_low_ff;
      acc_mid_in  = acc_mid_ff;
      acc_high_in = acc_high_ff;
      priority if (fin_fire) begin
         if (is_last_col) begin
            acc_low_in  = '0;
            acc_mid_in  = '0;
         end else begin
            acc_low_in  = acc_mid_ff;
            acc_mid_in  = WB'(acc_high_ff);
         end
         acc_high_in = '0;
      end else if (prod_fire || v2_ff) begin
         acc_low_in  = sum[WB-1:0];
         acc_mid_in  = sum[2*WB-1:WB];
         acc_high_in = acc_high_ff + HW'(sum[2*WB]);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fin_fire && !is_quot_col) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrsp_pkg::ST_IDLE;
         column_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         acc_low_ff   <= '0;
         acc_mid_ff   <= '0;
         acc_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         v1_ff        <= (state_ff == mrsp_pkg::ST_MAC);
         v2_ff        <= v1_ff;
         acc_low_ff   <= acc_low_in;
         acc_mid_ff   <= acc_mid_in;
         acc_high_ff  <= acc_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      jhi_ff  <= jhi_in;
      prod_ff <= 64'(q_rd) * 64'(m_rd);
      if (fin_fire && !is_quot_col) begin
         rsp_word_ff  <= acc_low_ff;
         rsp_index_ff <= mrsp_pkg::INDEX_BITS'(column_ff - CW'(WORDS));
         rsp_last_ff  <= is_last_col;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_index_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_drained_at_retire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrsp_pkg::ST_FIN) |-> (!v1_ff && !v2_ff))
      else $error("retire step reached with products still in flight");

   a_high_bound: assert property (@(posedge clock) disable iff (reset)
      32'(acc_high_ff) <= 32'(WORDS + 1))
      else $error("accumulator top word out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (fin_fire && is_last_col) |=> (column_ff == '0 && acc_low_ff == '0
                                     && acc_mid_ff == '0 && acc_high_ff == '0))
      else $error("state not cleared after the final result word");

   a_rsp_from_retire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mrsp_pkg::ST_FIN))
      else $error("result raised outside the retire step");

endmodule

// ===== bench/montgomery_reduce_special_prime_checker.sv =====
// Checker for the reduction core: predicts each reduced word from accepted requests and compares.
`timescale 1ns / 1ps

module montgomery_reduce_special_prime_checker #(
   parameter int WORDS      = 14,
   parameter int ZERO_WORDS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [mrsp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [mrsp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 rsp_tlast,
   output int                                   mismatch_count,
   output int                                   outstanding_words
);

   localparam int WORD_BITS  = mrsp_pkg::WORD_BITS;
   localparam int INDEX_BITS = mrsp_pkg::INDEX_BITS;

   typedef struct packed {
      logic [WORD_BITS-1:0]  result_word;
      logic [INDEX_BITS-1:0] result_index;
      logic                  last_flag;
   } reduced_word_type;

   logic [WORD_BITS-1:0]   modulus_table [WORDS];
   logic [WORD_BITS-1:0]   quotient [WORDS];
   // Three-word column accumulator: the top word only ever holds a few carries.
   logic [3*WORD_BITS-1:0] column_acc;
   int                     column;
   reduced_word_type       expected_words[$];

   task automatic absorb_request(input logic kind, input logic [INDEX_BITS-1:0] slot,
                                 input logic [WORD_BITS-1:0] data);
      logic [2*WORD_BITS-1:0] term;
      logic [WORD_BITS-1:0]   low_word;
      reduced_word_type       entry;
      int                     k;
      if (kind == mrsp_pkg::REQ_LOAD) begin
         if (slot < WORDS)
            modulus_table[slot] = data;
      end else begin
         // Only terms whose table word can be nonzero belong to this column.
         for (int j = 0; j < WORDS; j++) begin
            k = column - j;
            if (j < column && j + WORDS > column && k >= ZERO_WORDS && k < WORDS) begin
               term = {{WORD_BITS{1'b0}}, quotient[j]}
                      * {{WORD_BITS{1'b0}}, modulus_table[k]};
               column_acc = column_acc + {{WORD_BITS{1'b0}}, term};
            end
         end
         column_acc = column_acc + {{2*WORD_BITS{1'b0}}, data};
         low_word = column_acc[WORD_BITS-1:0];
         column_acc = column_acc >> WORD_BITS;
         if (column < WORDS) begin
            quotient[column] = low_word;
            column++;
         end else begin
            entry.result_word = low_word;
            entry.result_index = INDEX_BITS'(column - WORDS);
            entry.last_flag = (column == 2*WORDS - 1);
            expected_words.push_back(entry);
            if (entry.last_flag) begin
               // The carry out of the top column is dropped.
               column = 0;
               column_acc = '0;
            end else begin
               column++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch_channels
      reduced_word_type seen;
      reduced_word_type want;
      if (reset) begin
         expected_words.delete();
         column_acc = '0;
         column = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.result_word = rsp_tdata[WORD_BITS-1:0];
            seen.result_index = rsp_tdata[WORD_BITS +: INDEX_BITS];
            seen.last_flag = rsp_tlast;
            if (expected_words.size() == 0) begin
               $display({"%0t: unexpected result transaction, expected none, ",
                         "actual word %h index %0d last %b"},
                        $time, seen.result_word, seen.result_index, seen.last_flag);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (seen.result_word !== want.result_word) begin
                  $display("%0t: result_word mismatch, expected %h, actual %h",
                           $time, want.result_word, seen.result_word);
                  mismatch_count++;
               end
               if (seen.result_index !== want.result_index) begin
                  $display("%0t: result_index mismatch, expected %0d, actual %0d",
                           $time, want.result_index, seen.result_index);
                  mismatch_count++;
               end
               if (seen.last_flag !== want.last_flag) begin
                  $display("%0t: last mismatch, expected %b, actual %b",
                           $time, want.last_flag, seen.last_flag);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_request(req_tuser, req_tdata[INDEX_BITS-1:0],
                           req_tdata[INDEX_BITS +: WORD_BITS]);
      end
      outstanding_words <= expected_words.size();
   end

endmodule

// ===== bench/montgomery_reduce_special_prime_core_test.sv =====
// Testbench top for the reduction core: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module montgomery_reduce_special_prime_core_test;

   localparam int WORDS            = 14;
   localparam int ZERO_WORDS       = 6;
   localparam int OPERAND_COUNT    = 43;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int WORD_BITS        = mrsp_pkg::WORD_BITS;
   localparam int INDEX_BITS       = mrsp_pkg::INDEX_BITS;
   localparam int REQ_DATA_BITS    = mrsp_pkg::REQ_DATA_BITS;
   localparam int RSP_DATA_BITS    = mrsp_pkg::RSP_DATA_BITS;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // [3:0] table_index, [35:4] data_word, [39:36] zero
   logic                     req_tuser = 1'b0; // [0] req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // [31:0] result_word, [35:32] result_index
   logic                     rsp_tlast;

   int   mismatch_count;
   int   outstanding_words;
   int   cycle_count = 0;
   bit   sender_idles = 1'b0;
   bit   receiver_idles = 1'b0;
   logic hold_request = 1'b0;

   montgomery_reduce_special_prime_core #(
      .WORDS      (WORDS),
      .ZERO_WORDS (ZERO_WORDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   montgomery_reduce_special_prime_checker #(
      .WORDS      (WORDS),
      .ZERO_WORDS (ZERO_WORDS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .outstanding_words (outstanding_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request so the core backs up.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [WORD_BITS-1:0] random_word();
      logic [WORD_BITS-1:0] one_hot;
      one_hot = 1 << $urandom_range(0, WORD_BITS - 1);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return $urandom;
      endcase
   endfunction

   // Offers one transaction and returns at the edge where it is taken.
   task automatic send_request(input logic kind, input logic [INDEX_BITS-1:0] slot,
                               input logic [WORD_BITS-1:0] data);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_DATA_BITS - WORD_BITS - INDEX_BITS){1'b0}}, data, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding_words != 0);
   endtask

   task automatic load_table(input bit all_ones);
      for (int i = 0; i < WORDS; i++)
         send_request(mrsp_pkg::REQ_LOAD, INDEX_BITS'(i), all_ones ? '1 : random_word());
   endtask

   // One double-length operand, low word first, with the odd table write mixed in.
   task automatic reduce_operand(input bit all_ones);
      for (int i = 0; i < 2*WORDS; i++) begin
         if (!all_ones && $urandom_range(0, 23) == 0)
            send_request(mrsp_pkg::REQ_LOAD, INDEX_BITS'($urandom_range(0, 15)),
                         random_word());
         send_request(mrsp_pkg::REQ_PRODUCT, INDEX_BITS'($urandom_range(0, 15)),
                      all_ones ? '1 : random_word());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Words below ZERO_WORDS are never read, so all-ones there must not matter.
      load_table(1'b1);
      send_request(mrsp_pkg::REQ_LOAD, INDEX_BITS'(WORDS), '0);
      send_request(mrsp_pkg::REQ_LOAD, '1, '1);
      reduce_operand(1'b1);
      wait_for_results();

      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      for (int op = 0; op < OPERAND_COUNT; op++) begin
         if (op % 12 == 0)
            load_table(1'b0);
         if (op == 6)
            hold_request <= 1'b1;
         if (op == 20)
            wait_for_results();
         if (op == 16 || op == 30) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end
         if (op == 18 || op == 32) begin
            sender_idles = 1'b1;
            receiver_idles = 1'b1;
         end
         // The tail of the run goes at full rate on both sides.
         if (op == OPERAND_COUNT - 8) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end
         reduce_operand(1'b0);
      end

      wait_for_results();
      repeat (4*WORDS) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
